### rtl/trms_pkg.sv
package trms_pkg;

  // Record framing
  localparam int RECORD_BYTES = 19;
  localparam int POS_W        = 5;
  localparam logic [POS_W-1:0] POS_COORD  = 5'd13;
  localparam logic [POS_W-1:0] POS_EYE_R  = 5'd14;
  localparam logic [POS_W-1:0] POS_EYE_C  = 5'd15;
  localparam logic [POS_W-1:0] POS_EYE_L  = 5'd16;
  localparam logic [POS_W-1:0] POS_LED    = 5'd17;
  localparam logic [POS_W-1:0] POS_MODULE = 5'd18;
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(RECORD_BYTES - 1);

  localparam logic [3:0] EYE_MASK    = 4'h0F;
  localparam logic [6:0] LED_MASK    = 7'h7F;
  localparam logic [3:0] MODULE_MASK = 4'h0F;

  // Marker key is module*128 + LED
  localparam int KEY_W       = 11;
  localparam int MIN_ENTRIES = 16;
  localparam int QUO_W       = KEY_W - $clog2(MIN_ENTRIES);

  // Field widths
  localparam int CMD_W     = 2;
  localparam int OUT_W     = 24;
  localparam int MINF_W    = 24;
  localparam int THR_W     = 9;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  // Parameter defaults
  localparam int COUNT_WIDTH_DEF    = 24;
  localparam int MARKER_ENTRIES_DEF = 2048;

  // Register reset values
  localparam logic [MINF_W-1:0] MIN_FRAMES_RST   = 24'd10;
  localparam logic [THR_W-1:0]  THRESHOLD_RST    = 9'd128;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       link_byte;
    logic [3:0]       query_module;
    logic [6:0]       query_led;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] frames_total;
    logic [OUT_W-1:0] frames_valid;
    logic [OUT_W-1:0] frames_coord_ok;
    logic [OUT_W-1:0] frames_not_all_ok;
    logic             enough_frames;
    logic             present;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // input transfer this cycle
    logic upd_wr;     // write back updated counters
    logic clr_start;  // restart the clearing sweep
    logic clr_wr;     // clear one memory entry
    logic mul_ld;     // capture query read data and product
    logic out_ld;     // load the result register
  } trms_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic rec_end;    // byte position is the last of a record
    logic clr_last;   // sweep is at the last entry
    logic out_free;   // result register can take a new result
  } trms_sts_t;

endpackage

### rtl/trms_dp.sv
module trms_dp import trms_pkg::*; #(
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int MARKER_ENTRIES = MARKER_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_t                  in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_t                 out_data,
  input  trms_ctl_t            ctl,
  output trms_sts_t            sts
);

  localparam int AW     = $clog2(MARKER_ENTRIES);
  localparam int CW     = COUNT_WIDTH;
  localparam int WORD_W = 3 * CW + 1;
  localparam int SUB_W  = KEY_W + QUO_W;
  localparam int PROD_W = THR_W + CW;
  localparam int CMP_W  = (CW > MINF_W) ? CW : MINF_W;

  function automatic logic [AW-1:0] slot_of(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] rem;
    logic [SUB_W-1:0] step;
    rem = key;
    for (int j = QUO_W - 1; j >= 0; j--) begin
      step = SUB_W'(MARKER_ENTRIES) << j;
      if (SUB_W'(rem) >= step) begin
        rem = rem - KEY_W'(step);
      end
    end
    return AW'(rem);
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  // Configuration registers
  logic [MINF_W-1:0] min_frames_r;
  logic [THR_W-1:0]  thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_frames_r <= MIN_FRAMES_RST;
      thr_r        <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_FRAMES: min_frames_r <= cfg_wdata[MINF_W-1:0];
        REG_THRESHOLD:  thr_r        <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Record framing
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       coord_r, coord_nxt;
  logic             eyes_ok_r, eyes_ok_nxt;
  logic [6:0]       led_r, led_nxt;
  logic             is_byte;

  assign is_byte = ctl.take && (in_data.cmd == CMD_BYTE);

  always_comb begin
    pos_nxt     = pos_r;
    coord_nxt   = coord_r;
    eyes_ok_nxt = eyes_ok_r;
    led_nxt     = led_r;
    if (ctl.take && (in_data.cmd == CMD_CLEAR)) begin
      pos_nxt     = '0;
      coord_nxt   = '0;
      eyes_ok_nxt = 1'b0;
      led_nxt     = '0;
    end else if (is_byte) begin
      case (pos_r)
        POS_COORD: coord_nxt = in_data.link_byte[6:4];
        POS_EYE_R: eyes_ok_nxt = ((in_data.link_byte[3:0] & EYE_MASK) == '0);
        POS_EYE_C, POS_EYE_L: begin
          if ((in_data.link_byte[3:0] & EYE_MASK) != '0) begin
            eyes_ok_nxt = 1'b0;
          end
        end
        POS_LED: led_nxt = in_data.link_byte[6:0] & LED_MASK;
        default: ;
      endcase
      pos_nxt = (pos_r >= POS_LAST) ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      coord_r   <= '0;
      eyes_ok_r <= 1'b0;
      led_r     <= '0;
    end else begin
      pos_r     <= pos_nxt;
      coord_r   <= coord_nxt;
      eyes_ok_r <= eyes_ok_nxt;
      led_r     <= led_nxt;
    end
  end

  // Counter memory: {seen, coord_ok, valid, total}
  logic [WORD_W-1:0] mem [MARKER_ENTRIES];
  logic [WORD_W-1:0] rd_q;
  logic [AW-1:0]     rd_addr, wr_addr_r;
  logic [KEY_W-1:0]  key;
  logic [AW-1:0]     clr_cnt_r;

  always_comb begin
    if (in_data.cmd == CMD_BYTE) begin
      key = {in_data.link_byte[3:0] & MODULE_MASK, led_r};
    end else begin
      key = {in_data.query_module, in_data.query_led};
    end
  end

  assign rd_addr = slot_of(key);

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rd_q      <= mem[rd_addr];
      wr_addr_r <= rd_addr;
    end
  end

  logic          q_seen;
  logic [CW-1:0] q_tot, q_val, q_cok;
  logic [WORD_W-1:0] upd_word;

  // Unseen entries read as zero counts
  assign q_seen = rd_q[WORD_W-1];
  assign q_cok  = q_seen ? rd_q[3*CW-1:2*CW] : '0;
  assign q_val  = q_seen ? rd_q[2*CW-1:CW]   : '0;
  assign q_tot  = q_seen ? rd_q[CW-1:0]      : '0;

  assign upd_word = {1'b1,
                     (coord_r == '0) ? sat_inc(q_cok) : q_cok,
                     eyes_ok_r ? sat_inc(q_val) : q_val,
                     sat_inc(q_tot)};

  always_ff @(posedge clk) begin
    if (ctl.clr_wr) begin
      mem[clr_cnt_r] <= '0;
    end else if (ctl.upd_wr) begin
      mem[wr_addr_r] <= upd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr_start) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Query: product stage, then compare into result register
  logic              seen_r;
  logic [CW-1:0]     tot_r, val_r, cok_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_ld) begin
      seen_r <= q_seen;
      tot_r  <= q_tot;
      val_r  <= q_val;
      cok_r  <= q_cok;
      prod_r <= PROD_W'(thr_r) * PROD_W'(q_tot);
    end
  end

  logic   enough, rate_ok, out_valid_r;
  out_t   out_r;
  logic [CW-1:0] diff;

  assign enough  = CMP_W'(tot_r) >= CMP_W'(min_frames_r);
  assign rate_ok = PROD_W'({val_r, 8'h00}) >= prod_r;
  assign diff    = tot_r - val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      out_r.frames_total      <= OUT_W'(tot_r);
      out_r.frames_valid      <= OUT_W'(val_r);
      out_r.frames_coord_ok   <= OUT_W'(cok_r);
      out_r.frames_not_all_ok <= OUT_W'(diff);
      out_r.enough_frames     <= enough;
      out_r.present           <= seen_r && enough && rate_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.rec_end  = (pos_r == POS_MODULE);
  assign sts.clr_last = (clr_cnt_r == AW'(MARKER_ENTRIES - 1));
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

### rtl/trms_ctrl.sv
module trms_ctrl import trms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  trms_sts_t        sts,
  output trms_ctl_t        ctl
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_UPD,
    S_QMUL,
    S_QOUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take = 1'b1;
          case (in_cmd)
            CMD_BYTE: begin
              if (sts.rec_end) begin
                state_nxt = S_UPD;
              end
            end
            CMD_QUERY: state_nxt = S_QMUL;
            CMD_CLEAR: begin
              ctl.clr_start = 1'b1;
              state_nxt     = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_UPD: begin
        ctl.upd_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_QMUL: begin
        ctl.mul_ld = 1'b1;
        state_nxt  = S_QOUT;
      end
      S_QOUT: begin
        // hold until the result register is free
        if (sts.out_free) begin
          ctl.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/tracker_record_marker_statistics_unit.sv
// Link bytes: the last byte of a record also takes an update step (counter memory
// read, then saturating update and write back through its single port) before the
// next input is taken. Query: counter memory read, product stage, result register;
// next item taken once the result is loaded, or later while the previous result
// still waits in the result register. Reset and the clear command sweep the counter
// memory, one entry a cycle, with no input taken; configuration writes taken always.
// Reset is synchronous, active low; registers return to min_frames 10, threshold 128.
module tracker_record_marker_statistics_unit import trms_pkg::*; #(
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int MARKER_ENTRIES = MARKER_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  trms_ctl_t ctl;
  trms_sts_t sts;

  trms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  trms_dp #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .MARKER_ENTRIES (MARKER_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import trms_pkg::*;

  localparam int MARKERS = 2048;
  localparam int IN_BITS = $bits(in_t);
  localparam int POOL_SIZE = 4;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Marker statistics model
  logic [MINF_W-1:0] min_frames_q;
  logic [THR_W-1:0] thr_q8;
  logic [POS_W-1:0] frame_pos;
  logic [2:0] held_coord;
  logic held_eyes_ok;
  logic [6:0] held_led;
  bit marker_seen [MARKERS];
  logic [OUT_W-1:0] total_cnt [MARKERS];
  logic [OUT_W-1:0] valid_cnt [MARKERS];
  logic [OUT_W-1:0] coord_cnt [MARKERS];
  out_t expected_counts [$];

  logic [10:0] marker_pool [POOL_SIZE];
  int items_sent = 0;
  int mismatches = 0;
  int send_gap_pct = 14;
  int recv_gap_pct = 14;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  tracker_record_marker_statistics_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic wipe_markers();
    foreach (marker_seen[i]) begin
      marker_seen[i] = 1'b0;
      total_cnt[i] = '0;
      valid_cnt[i] = '0;
      coord_cnt[i] = '0;
    end
    frame_pos = '0;
    held_coord = '0;
    held_eyes_ok = 1'b0;
    held_led = '0;
  endtask

  task automatic predict_marker_stats(input in_t item);
    logic [10:0] idx;
    logic [OUT_W-1:0] tot, val, cok;
    out_t want;
    case (item.cmd)
      CMD_BYTE: begin
        case (frame_pos)
          POS_COORD: held_coord = item.link_byte[6:4];
          POS_EYE_R: held_eyes_ok = (item.link_byte[3:0] == 4'd0);
          POS_EYE_C, POS_EYE_L: if (item.link_byte[3:0] != 4'd0) held_eyes_ok = 1'b0;
          POS_LED: held_led = item.link_byte[6:0];
          POS_MODULE: begin
            idx = {item.link_byte[3:0], held_led};
            if (!marker_seen[idx]) begin
              marker_seen[idx] = 1'b1;
              total_cnt[idx] = '0;
              valid_cnt[idx] = '0;
              coord_cnt[idx] = '0;
            end
            total_cnt[idx] = bump(total_cnt[idx]);
            if (held_eyes_ok) valid_cnt[idx] = bump(valid_cnt[idx]);
            if (held_coord == 3'd0) coord_cnt[idx] = bump(coord_cnt[idx]);
          end
          default: ;
        endcase
        frame_pos = (frame_pos == POS_LAST) ? '0 : frame_pos + 1'b1;
      end
      CMD_QUERY: begin
        idx = {item.query_module, item.query_led};
        tot = marker_seen[idx] ? total_cnt[idx] : '0;
        val = marker_seen[idx] ? valid_cnt[idx] : '0;
        cok = marker_seen[idx] ? coord_cnt[idx] : '0;
        want.frames_total = tot;
        want.frames_valid = val;
        want.frames_coord_ok = cok;
        want.frames_not_all_ok = tot - val;
        want.enough_frames = (tot >= min_frames_q);
        want.present = marker_seen[idx] && want.enough_frames &&
                       ((64'(val) << 8) >= 64'(thr_q8) * 64'(tot));
        expected_counts = {expected_counts, want};
      end
      CMD_CLEAR: wipe_markers();
      default: ;
    endcase
  endtask

  function automatic in_t byte_item(input logic [7:0] b);
    in_t it;
    it = in_t'(IN_BITS'($urandom));
    it.cmd = CMD_BYTE;
    it.link_byte = b;
    return it;
  endfunction

  function automatic in_t query_item(input logic [10:0] key);
    in_t it;
    it = in_t'(IN_BITS'($urandom));
    it.cmd = CMD_QUERY;
    it.query_module = key[10:7];
    it.query_led = key[6:0];
    return it;
  endfunction

  function automatic in_t other_item(input logic [CMD_W-1:0] code);
    in_t it;
    it = in_t'(IN_BITS'($urandom));
    it.cmd = code;
    return it;
  endfunction

  // Hold valid and payload until the transfer, then update the model.
  task automatic send_item(input in_t item);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      in_data <= in_t'(IN_BITS'($urandom));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.cmd != CMD_UNUSED) items_sent++;
    predict_marker_stats(item);
  endtask

  // Drop valid and wait out every pending result plus trailing record work.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [MINF_W-1:0] minf, input logic [THR_W-1:0] thr);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_FRAMES;
    cfg_wdata <= CFG_W'(minf);
    @(posedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    min_frames_q = minf;
    thr_q8 = thr;
  endtask

  task automatic pick_markers();
    foreach (marker_pool[i])
      marker_pool[i] = ($urandom_range(5) == 0) ? {11{1'($urandom_range(1))}}
                                                : 11'($urandom);
  endtask

  // Send the first count bytes of a record for one marker, queries sprinkled in.
  task automatic send_record(input logic [10:0] key, input int count);
    logic [7:0] rec [RECORD_BYTES];
    foreach (rec[i]) rec[i] = 8'($urandom);
    if ($urandom_range(1)) rec[POS_COORD][6:4] = 3'd0;
    for (int e = POS_EYE_R; e <= POS_EYE_L; e++)
      rec[e][3:0] = ($urandom_range(9) < 7) ? 4'd0 : 4'($urandom_range(1, 15));
    rec[POS_LED][6:0] = key[6:0];
    rec[POS_MODULE][3:0] = key[10:7];
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5)
        send_item(query_item(marker_pool[$urandom_range(POOL_SIZE - 1)]));
      if ($urandom_range(99) < 2) send_item(other_item(CMD_UNUSED));
      send_item(byte_item(rec[i]));
    end
  endtask

  task automatic run_traffic(input int count);
    int pick;
    int goal;
    logic [10:0] key;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      key = marker_pool[$urandom_range(POOL_SIZE - 1)];
      if (pick < 78) begin
        // realign framing before a well-formed record
        while (frame_pos != '0) send_item(byte_item(8'($urandom)));
        send_record(key, RECORD_BYTES);
      end else if (pick < 88) begin
        send_item(query_item(pick < 85 ? key : 11'($urandom)));
      end else if (pick < 91) begin
        send_item(other_item(CMD_CLEAR));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 25)) send_item(byte_item(8'($urandom)));
      end else begin
        send_record(key, $urandom_range(1, RECORD_BYTES - 1));
        send_item(other_item(CMD_CLEAR));
      end
    end
  endtask

  task automatic test_directed_cases();
    send_item(query_item(11'h7FF));
    send_item(other_item(CMD_UNUSED));
    repeat (10) send_item(byte_item(8'hFF));
    send_item(query_item(11'h7FF));
    repeat (RECORD_BYTES - 10) send_item(byte_item(8'hFF));
    send_item(query_item(11'h7FF));
    repeat (5) send_item(byte_item(8'h00));
    send_item(query_item(11'h7FF));
    send_item(other_item(CMD_CLEAR));
    send_item(query_item(11'h7FF));
  endtask

  task automatic test_register_extremes();
    repeat (RECORD_BYTES) send_item(byte_item(8'hFF));
    repeat (RECORD_BYTES) send_item(byte_item(8'h00));
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: program_regs('0, '0);
        1: program_regs(24'd1, 9'd256);
        2: program_regs('1, '1);
        default: program_regs(MIN_FRAMES_RST, THRESHOLD_RST);
      endcase
      send_item(query_item(11'h7FF));
      send_item(query_item(11'h000));
      send_item(query_item(11'h3C5));
    end
  endtask

  task automatic test_random_traffic();
    pick_markers();
    run_traffic(250);
  endtask

  task automatic test_back_to_back();
    program_regs(24'd1, 9'd128);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    pick_markers();
    run_traffic(200);
    send_gap_pct = 14;
    recv_gap_pct = 14;
  endtask

  task automatic test_output_backpressure();
    program_regs('0, '0);
    hold_request = HOLD_CYCLES;
    repeat (40) send_item(query_item(marker_pool[$urandom_range(POOL_SIZE - 1)]));
    run_traffic(60);
  endtask

  task automatic test_threshold_sweep();
    logic [THR_W-1:0] thr;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: thr = 9'd256;
        1: thr = '1;
        2: thr = '0;
        default: thr = 9'($urandom_range(0, 256));
      endcase
      program_regs(24'($urandom_range(0, 4)), thr);
      pick_markers();
      run_traffic(100);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
                                      input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        $error("result transfer with no query pending");
        mismatches++;
      end else begin
        want = expected_counts.pop_front();
        check_field("frames_total", want.frames_total, out_data.frames_total);
        check_field("frames_valid", want.frames_valid, out_data.frames_valid);
        check_field("frames_coord_ok", want.frames_coord_ok, out_data.frames_coord_ok);
        check_field("frames_not_all_ok", want.frames_not_all_ok,
                    out_data.frames_not_all_ok);
        check_field("enough_frames", OUT_W'(want.enough_frames),
                    OUT_W'(out_data.enough_frames));
        check_field("present", OUT_W'(want.present), OUT_W'(out_data.present));
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    min_frames_q = MIN_FRAMES_RST;
    thr_q8 = THRESHOLD_RST;
    wipe_markers();
    foreach (marker_pool[i]) marker_pool[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    test_back_to_back();
    test_output_backpressure();
    test_threshold_sweep();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/trms_pkg.sv
rtl/trms_dp.sv
rtl/trms_ctrl.sv
rtl/tracker_record_marker_statistics_unit.sv
sim/testbench.sv
